@@ rtl/slnp_pkg.sv @@
// Shared types and constants for the sorted list node pool.
package slnp_pkg;

  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_INSERT   = 2'd1,
    MODE_DELETE   = 2'd2,
    MODE_TRAVERSE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_CMP  = 3'd1,
    CELL_INS  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_ROT  = 3'd4,
    CELL_CLR  = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0] key;
  } cell_ctrl_t;

endpackage

@@ rtl/slnp_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
interface slnp_cmd_if
  import slnp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slnp_res_if
  import slnp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] element;
  logic                      last;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, output status, output element, output last, output count,
                  input ready);
  modport sink   (input valid, input status, input element, input last, input count,
                  output ready);
endinterface

@@ rtl/slnp_cell.sv @@
// One storage cell of the sorted row: holds a value, compares it and shifts with neighbors.
module slnp_cell
  import slnp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic                      left_vld,
  input  logic                      left_ge,
  input  logic signed [VALUE_W-1:0] right_val,
  input  logic                      right_vld,
  input  logic signed [VALUE_W-1:0] head_val,
  output logic signed [VALUE_W-1:0] val,
  output logic                      vld,
  output logic                      ge,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      vld_r, vld_nxt;
  logic                      ge_r, ge_nxt;
  logic                      eq_r, eq_nxt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    ge_nxt  = ge_r;
    eq_nxt  = eq_r;
    unique case (ctrl.op)
      CELL_CMP: begin
        // an empty cell counts as greater than any key
        ge_nxt = !vld_r || (val_r >= ctrl.key);
        eq_nxt = vld_r && (val_r == ctrl.key);
      end
      CELL_INS: begin
        if (left_ge) begin
          val_nxt = left_val;
          vld_nxt = left_vld;
        end else if (ge_r) begin
          val_nxt = ctrl.key;
          vld_nxt = 1'b1;
        end
      end
      CELL_DEL: begin
        if (ge_r) begin
          val_nxt = right_val;
          vld_nxt = right_vld;
        end
      end
      CELL_ROT: begin
        // last occupied cell wraps the head value around
        if (right_vld) begin
          val_nxt = right_val;
        end else if (vld_r) begin
          val_nxt = head_val;
        end
      end
      CELL_CLR: begin
        vld_nxt = 1'b0;
      end
      CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      ge_r  <= 1'b0;
      eq_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      ge_r  <= ge_nxt;
      eq_r  <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;
  assign ge  = ge_r;
  assign eq  = eq_r;

endmodule

@@ rtl/slnp_row.sv @@
// Chain of storage cells kept in ascending order, with the delete hit detection.
module slnp_row
  import slnp_pkg::*;
#(
  parameter int N = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctrl_t                ctrl,
  output logic signed [VALUE_W-1:0] head_val,
  output logic                      found
);

  logic signed [VALUE_W-1:0] val [N];
  logic [N-1:0]              vld;
  logic [N-1:0]              ge;
  logic [N-1:0]              eq;
  logic [N-1:0]              hit;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [VALUE_W-1:0] l_val, r_val;
    logic                      l_vld, l_ge, r_vld;

    if (i == 0) begin : g_first
      assign l_val = '0;
      assign l_vld = 1'b0;
      assign l_ge  = 1'b0;
      assign hit[i] = ge[i] && eq[i];
    end else begin : g_mid
      assign l_val = val[i-1];
      assign l_vld = vld[i-1];
      assign l_ge  = ge[i-1];
      assign hit[i] = ge[i] && !ge[i-1] && eq[i];
    end

    if (i == N - 1) begin : g_last
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_val = val[i+1];
      assign r_vld = vld[i+1];
    end

    slnp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_val  (l_val),
      .left_vld  (l_vld),
      .left_ge   (l_ge),
      .right_val (r_val),
      .right_vld (r_vld),
      .head_val  (val[0]),
      .val       (val[i]),
      .vld       (vld[i]),
      .ge        (ge[i]),
      .eq        (eq[i])
    );
  end

  assign head_val = val[0];
  // only the first cell at or above the key can match
  assign found    = |hit;

endmodule

@@ rtl/sorted_list_node_pool_top.sv @@
// Sorted list of signed values in a pool of POOL_NODES cells: clear, insert, delete, traverse.
// Values sit in a row of cells kept in ascending order; an insert shifts the upper part
// right by one, a delete shifts it left, and a traverse rotates the occupied cells one place
// per result so the list is back in order when it ends. Clear goes straight to the apply state,
// insert and delete pass a compare state (a compare in every cell) before the shift, and a
// traverse gives one result per value stored (one if empty), each waiting on out_ch.ready.
// One request is worked on at a time; in_ch.ready is high only between requests. A result
// sits in an output register and the next request is taken while it waits to be read.
module sorted_list_node_pool_top
  import slnp_pkg::*;
#(
  parameter int POOL_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  slnp_cmd_if.sink    in_ch,
  slnp_res_if.source  out_ch
);

  localparam int CNT_W = $clog2(POOL_NODES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_TRAV
  } state_t;

  state_t                    state_r, state_nxt;
  mode_t                     mode_r, mode_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          step_r, step_nxt;
  logic                      out_vld_r, out_vld_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_elem_r, out_elem_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] head_val;
  logic                      found;
  logic                      out_free;
  logic                      full;
  logic                      empty;
  logic                      trav_last;
  logic [CNT_W-1:0]          res_cnt;

  slnp_row #(.N(POOL_NODES)) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .head_val (head_val),
    .found    (found)
  );

  assign out_free  = !out_vld_r || out_ch.ready;
  assign full      = (count_r == CNT_W'(POOL_NODES));
  assign empty     = (count_r == '0);
  assign trav_last = (step_r == count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    res_cnt        = count_r;
    ctrl.op        = CELL_HOLD;
    ctrl.key       = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = mode_t'(in_ch.mode);
          key_nxt  = in_ch.value;
          step_nxt = '0;
          unique case (mode_t'(in_ch.mode))
            MODE_CLEAR:    state_nxt = S_APPLY;
            MODE_TRAVERSE: state_nxt = S_TRAV;
            MODE_INSERT,
            MODE_DELETE:   state_nxt = S_CMP;
          endcase
        end
      end
      S_CMP: begin
        ctrl.op   = CELL_CMP;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_elem_nxt   = key_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
          unique case (mode_r)
            MODE_CLEAR: begin
              ctrl.op = CELL_CLR;
              res_cnt = '0;
            end
            MODE_INSERT: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.op = CELL_INS;
                res_cnt = count_r + 1'b1;
              end
            end
            MODE_DELETE: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else if (!found) begin
                out_status_nxt = ST_NOT_FOUND;
              end else begin
                ctrl.op = CELL_DEL;
                res_cnt = count_r - 1'b1;
              end
            end
            MODE_TRAVERSE: begin
            end
          endcase
          count_nxt     = res_cnt;
          out_count_nxt = COUNT_W'(res_cnt);
        end
      end
      S_TRAV: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_count_nxt = COUNT_W'(count_r);
          if (empty) begin
            out_status_nxt = ST_EMPTY;
            out_elem_nxt   = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // emit the head and rotate the occupied cells by one
            ctrl.op        = CELL_ROT;
            out_status_nxt = ST_OK;
            out_elem_nxt   = head_val;
            out_last_nxt   = trav_last;
            step_nxt       = step_r + 1'b1;
            if (trav_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      step_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      step_r    <= step_nxt;
      out_vld_r <= out_vld_nxt;
    end
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_vld_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.element = out_elem_r;
  assign out_ch.last    = out_last_r;
  assign out_ch.count   = out_count_r;

endmodule

@@ rtl/slnp_checker.sv @@
// Port-level checks for the sorted list node pool, bound to the top level.
module slnp_checker
  import slnp_pkg::*;
#(
  parameter int POOL_NODES = 32
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [STATUS_W-1:0]       out_status,
  input logic signed [VALUE_W-1:0] out_element,
  input logic                      out_last,
  input logic [COUNT_W-1:0]        out_count
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous request still in progress");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) && $stable(out_status)
      && $stable(out_last) && $stable(out_count))
    else $error("stalled result changed");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count == '0) && out_last)
    else $error("empty status with stored values or without last");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_count == COUNT_W'(POOL_NODES) && out_last)
    else $error("full status reported below pool size");

endmodule

bind sorted_list_node_pool_top slnp_checker #(.POOL_NODES(POOL_NODES)) u_slnp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_element (out_ch.element),
  .out_last    (out_ch.last),
  .out_count   (out_ch.count)
);
